>>> design/inode_cache_lfu_table_top_macros.svh
// ----------------------------------------------------------------------------
// Inode cache LFU table assertion macros
// Shared helpers for writing clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef INODE_CACHE_LFU_TABLE_TOP_MACROS_SVH
`define INODE_CACHE_LFU_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ILFU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ILFU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ilfu_pkg.sv
// ----------------------------------------------------------------------------
// Inode cache LFU table package
// Sizes, codes and payload types shared by the table's modules.
// ----------------------------------------------------------------------------
package ilfu_pkg;

   localparam int NUM_SLOTS = 64;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

   localparam logic [31:0] INODES_PER_BLOCK = 32'd4;
   localparam logic [31:0] INODE_BYTES      = 32'd256;

   localparam logic [7:0]  SHARE_MAX = 8'hFF;
   localparam logic [15:0] USE_MAX   = 16'hFFFF;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_SLOT = 2'd1,
      STATUS_UNHELD  = 2'd2
   } status_type;

   typedef struct packed {
      logic        op;
      logic [7:0]  device;
      logic [31:0] inode_number;
      logic [5:0]  release_slot;
      logic        dirty;
   } req_type;

   typedef struct packed {
      logic [5:0]  slot;
      logic        hit;
      logic        load_needed;
      logic        write_back;
      logic [31:0] disk_block;
      logic [9:0]  byte_offset;
      status_type  status;
   } rsp_type;

   // One slot as it is stored in the table memory.
   typedef struct packed {
      logic        modified;
      logic [15:0] use_count;
      logic [7:0]  share_count;
      logic [31:0] inode;
      logic [7:0]  device;
   } entry_type;

endpackage

>>> design/ilfu_locate.sv
// ----------------------------------------------------------------------------
// Inode location
// Turns a zero-based inode index into its disk block and byte offset.
// ----------------------------------------------------------------------------
module ilfu_locate (
   input  logic [31:0] inode_index,
   input  logic [31:0] table_start,
   output logic [31:0] disk_block,
   output logic [9:0]  byte_offset
);

   logic [31:0] quot;
   logic [31:0] rem;
   logic [31:0] offset_full;

   assign quot        = inode_index / ilfu_pkg::INODES_PER_BLOCK;
   assign rem         = inode_index % ilfu_pkg::INODES_PER_BLOCK;
   assign offset_full = rem * ilfu_pkg::INODE_BYTES;

   // Both the block sum and the offset wrap to the width of the result.
   assign disk_block  = quot + table_start;
   assign byte_offset = offset_full[9:0];

endmodule

>>> design/inode_cache_lfu_table_top.sv
// ----------------------------------------------------------------------------
// Inode cache LFU table
// Slot table for cached inodes with least-frequently-used replacement.
// ----------------------------------------------------------------------------
//  Channel   Ports                           Transfer
//  request   start, busy, req                start high while busy is low
//  result    rsp_strobe, rsp                 one cycle per strobe, no stall
//  register  csr_wr_en, csr_wr_data          any cycle with csr_wr_en high
//
//  A get reads every slot of the table memory once, one per cycle, keeping
//  busy high throughout; the result strobe rises as busy falls.
//  A put reads its slot once and writes it back only if the slot is held;
//  a write-back adds state PLOC after PMOD. The next request may start while
//  a result shows. Reset is synchronous; the table is usable right after.
// ----------------------------------------------------------------------------
module inode_cache_lfu_table_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ilfu_pkg::req_type   req,
   output logic                rsp_strobe,
   output ilfu_pkg::rsp_type   rsp,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_FILL  = 5'b00100,
      ST_PMOD  = 5'b01000,
      ST_PLOC  = 5'b10000
   } state_type;

   localparam int SW = ilfu_pkg::SLOT_W;
   localparam int CW = ilfu_pkg::CNT_W;

   state_type state_ff, state_in;

   ilfu_pkg::entry_type mem [ilfu_pkg::NUM_SLOTS];
   ilfu_pkg::entry_type rd_q_ff;
   logic                mem_re;
   logic [SW-1:0]       mem_raddr;
   logic                mem_we;
   logic [SW-1:0]       mem_waddr;
   ilfu_pkg::entry_type mem_wdata;

   logic [ilfu_pkg::NUM_SLOTS-1:0] valid_ff, valid_in;

   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           rd_vld_ff, rd_vld_in;
   logic [SW-1:0]  rd_idx_ff, rd_idx_in;

   logic [7:0]     key_dev_ff, key_dev_in;
   logic [31:0]    key_ino_ff, key_ino_in;
   logic           dirty_ff, dirty_in;
   logic [5:0]     rel_ff, rel_in;
   logic           rel_ok_ff, rel_ok_in;
   logic [31:0]    loc_idx_ff, loc_idx_in;
   logic [31:0]    table_start_ff;

   logic                hit_found_ff, hit_found_in;
   logic [SW-1:0]       hit_idx_ff, hit_idx_in;
   ilfu_pkg::entry_type hit_entry_ff, hit_entry_in;
   logic                free_found_ff, free_found_in;
   logic [SW-1:0]       free_idx_ff, free_idx_in;
   logic                vic_found_ff, vic_found_in;
   logic [SW-1:0]       vic_idx_ff, vic_idx_in;
   logic [15:0]         vic_use_ff, vic_use_in;

   ilfu_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   logic [31:0] loc_block;
   logic [9:0]  loc_offset;

   // Per-entry tests on the word that the scan has just read back.
   logic rd_slot_valid;
   logic rd_match;
   logic rd_free;
   logic rd_victim;

   // Put path.
   logic                put_held;
   ilfu_pkg::entry_type put_entry;
   ilfu_pkg::entry_type hit_update;
   ilfu_pkg::entry_type fill_entry;

   ilfu_locate u_locate (
      .inode_index (loc_idx_ff),
      .table_start (table_start_ff),
      .disk_block  (loc_block),
      .byte_offset (loc_offset)
   );

   assign rd_slot_valid = valid_ff[rd_idx_ff];
   assign rd_match  = rd_slot_valid && (rd_q_ff.device == key_dev_ff) &&
                      (rd_q_ff.inode == key_ino_ff);
   assign rd_free   = !rd_slot_valid;
   assign rd_victim = rd_slot_valid && (rd_q_ff.share_count == 8'd0) &&
                      (!vic_found_ff || (rd_q_ff.use_count < vic_use_ff));

   assign put_held = rel_ok_ff && valid_ff[SW'(rel_ff)] && (rd_q_ff.share_count != 8'd0);

   always_comb begin
      put_entry = rd_q_ff;
      put_entry.modified    = rd_q_ff.modified | dirty_ff;
      put_entry.share_count = rd_q_ff.share_count - 8'd1;
      if ((put_entry.share_count == 8'd0) && put_entry.modified) begin
         put_entry.modified = 1'b0;
      end
   end

   always_comb begin
      hit_update = hit_entry_ff;
      if (hit_entry_ff.share_count != ilfu_pkg::SHARE_MAX) begin
         hit_update.share_count = hit_entry_ff.share_count + 8'd1;
      end
      if (hit_entry_ff.use_count != ilfu_pkg::USE_MAX) begin
         hit_update.use_count = hit_entry_ff.use_count + 16'd1;
      end
   end

   always_comb begin
      fill_entry.modified    = 1'b0;
      fill_entry.use_count   = 16'd1;
      fill_entry.share_count = 8'd1;
      fill_entry.inode       = key_ino_ff;
      fill_entry.device      = key_dev_ff;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = cnt_ff[SW-1:0];
      mem_re        = 1'b0;
      mem_raddr     = cnt_ff[SW-1:0];
      mem_we        = 1'b0;
      mem_waddr     = hit_idx_ff;
      mem_wdata     = hit_update;
      valid_in      = valid_ff;
      key_dev_in    = key_dev_ff;
      key_ino_in    = key_ino_ff;
      dirty_in      = dirty_ff;
      rel_in        = rel_ff;
      rel_ok_in     = rel_ok_ff;
      loc_idx_in    = loc_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_entry_in  = hit_entry_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      vic_found_in  = vic_found_ff;
      vic_idx_in    = vic_idx_ff;
      vic_use_in    = vic_use_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_dev_in = req.device;
               key_ino_in = req.inode_number;
               dirty_in   = req.dirty;
               rel_in     = req.release_slot;
               loc_idx_in = req.inode_number - 32'd1;
               if (req.op == ilfu_pkg::OP_GET) begin
                  cnt_in        = '0;
                  hit_found_in  = 1'b0;
                  free_found_in = 1'b0;
                  vic_found_in  = 1'b0;
                  state_in      = ST_SCAN;
               end else begin
                  rel_ok_in = 11'(req.release_slot) < 11'(ilfu_pkg::NUM_SLOTS);
                  mem_re    = 1'b1;
                  mem_raddr = SW'(req.release_slot);
                  state_in  = ST_PMOD;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff < CW'(ilfu_pkg::NUM_SLOTS)) begin
               mem_re    = 1'b1;
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               // Only the first match and the first free slot count.
               if (rd_match && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_entry_in = rd_q_ff;
               end
               if (rd_free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               // A strict compare keeps the lowest index among equal counts.
               if (rd_victim) begin
                  vic_found_in = 1'b1;
                  vic_idx_in   = rd_idx_ff;
                  vic_use_in   = rd_q_ff.use_count;
               end
               if (rd_idx_ff == SW'(ilfu_pkg::NUM_SLOTS - 1)) begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            rsp_in             = '0;
            rsp_in.disk_block  = loc_block;
            rsp_in.byte_offset = loc_offset;
            rsp_in.status      = ilfu_pkg::STATUS_OK;
            if (hit_found_ff) begin
               mem_we     = 1'b1;
               rsp_in.slot = 6'(hit_idx_ff);
               rsp_in.hit  = 1'b1;
            end else if (free_found_ff) begin
               mem_we                = 1'b1;
               mem_waddr             = free_idx_ff;
               mem_wdata             = fill_entry;
               valid_in[free_idx_ff] = 1'b1;
               rsp_in.slot           = 6'(free_idx_ff);
               rsp_in.load_needed    = 1'b1;
            end else if (vic_found_ff) begin
               mem_we             = 1'b1;
               mem_waddr          = vic_idx_ff;
               mem_wdata          = fill_entry;
               rsp_in.slot        = 6'(vic_idx_ff);
               rsp_in.load_needed = 1'b1;
            end else begin
               rsp_in.status = ilfu_pkg::STATUS_NO_SLOT;
            end
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_PMOD: begin
            rsp_in      = '0;
            rsp_in.slot = rel_ff;
            if (!put_held) begin
               rsp_in.status = ilfu_pkg::STATUS_UNHELD;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = SW'(rel_ff);
               mem_wdata = put_entry;
               if ((put_entry.share_count == 8'd0) &&
                   (rd_q_ff.modified || dirty_ff)) begin
                  loc_idx_in = rd_q_ff.inode - 32'd1;
                  state_in   = ST_PLOC;
               end else begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_PLOC: begin
            rsp_in             = '0;
            rsp_in.slot        = rel_ff;
            rsp_in.write_back  = 1'b1;
            rsp_in.disk_block  = loc_block;
            rsp_in.byte_offset = loc_offset;
            rsp_in.status      = ilfu_pkg::STATUS_OK;
            rsp_strobe_in      = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_q_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         valid_ff       <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         table_start_ff <= '0;
         hit_found_ff   <= 1'b0;
         free_found_ff  <= 1'b0;
         vic_found_ff   <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         vic_found_ff  <= vic_found_in;
         cnt_ff        <= cnt_in;
         if (csr_wr_en) begin
            table_start_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      key_dev_ff   <= key_dev_in;
      key_ino_ff   <= key_ino_in;
      dirty_ff     <= dirty_in;
      rel_ff       <= rel_in;
      rel_ok_ff    <= rel_ok_in;
      loc_idx_ff   <= loc_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      free_idx_ff  <= free_idx_in;
      vic_idx_ff   <= vic_idx_in;
      vic_use_ff   <= vic_use_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

>>> design/ilfu_checker.sv
// ----------------------------------------------------------------------------
// Inode cache LFU table checker
// Port-level checks on request intake and result fields, bound to the top.
// ----------------------------------------------------------------------------
`include "inode_cache_lfu_table_top_macros.svh"

module ilfu_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input ilfu_pkg::rsp_type rsp
);

   // Every accepted request raises busy in the next cycle.
   `ILFU_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "request not taken")

   // Every request passes through a busy state before its result, so results never come back to back.
   `ILFU_ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe, "results back to back")

   `ILFU_ASSERT_NOW(a_no_slot_fields, clock, reset,
      rsp_strobe && (rsp.status == ilfu_pkg::STATUS_NO_SLOT),
      !rsp.hit && !rsp.load_needed && (rsp.slot == 6'd0), "bad no-slot result")

   `ILFU_ASSERT_NOW(a_flags_exclusive, clock, reset, rsp_strobe,
      !(rsp.hit && rsp.load_needed) && !(rsp.write_back && (rsp.hit || rsp.load_needed)),
      "conflicting result flags")

endmodule

bind inode_cache_lfu_table_top ilfu_checker u_ilfu_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp        (rsp)
);

>>> tb/inode_cache_lfu_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inode cache LFU table testbench
// Sends get and put requests to the slot table and checks every result
// against a typed row's expected value or a cycle-free model of the table
// kept here: key lookup, fill of unused slots, least-used victim choice,
// share and use counts, modified marks and the on-disk location. A short
// list of directed requests comes first, then random traffic in phases that
// mix, fill, drain and hammer the table, each under its own inode table start.
// ----------------------------------------------------------------------------
module inode_cache_lfu_table_top_tb;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int RANDOM_ITEMS  = 1840;
   localparam int POOL_SIZE     = 96;
   localparam int HAMMER_KEY    = 2;
   localparam int SETTLE_CYCLES = 80;

   typedef enum logic {ROW_REQ, ROW_CFG} row_kind_type;
   typedef enum logic [1:0] {MODE_MIXED, MODE_FILL, MODE_DRAIN, MODE_HAMMER} traffic_mode_type;

   typedef struct {
      row_kind_type      kind;
      ilfu_pkg::req_type request;
      bit                typed;
      ilfu_pkg::rsp_type want;
      logic [31:0]       cfg_value;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   ilfu_pkg::req_type req = '0;
   logic              rsp_strobe;
   ilfu_pkg::rsp_type rsp;
   logic              csr_wr_en = 1'b0;
   logic [31:0]       csr_wr_data = '0;

   // Table model.
   logic        cached_valid  [ilfu_pkg::NUM_SLOTS];
   logic [7:0]  cached_device [ilfu_pkg::NUM_SLOTS];
   logic [31:0] cached_inode  [ilfu_pkg::NUM_SLOTS];
   logic [7:0]  share_cnt     [ilfu_pkg::NUM_SLOTS];
   logic [15:0] use_cnt       [ilfu_pkg::NUM_SLOTS];
   logic        modified      [ilfu_pkg::NUM_SLOTS];
   logic [31:0] table_start;

   ilfu_pkg::rsp_type pending_rsp[$];
   stim_row_type      directed_rows[$];
   logic [7:0]        pool_device[POOL_SIZE];
   logic [31:0]       pool_inode[POOL_SIZE];
   int                errors = 0;
   int                cycles = 0;

   inode_cache_lfu_table_top DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Block number and byte offset of an inode, packed as {block, offset}.
   function automatic logic [41:0] inode_location(logic [31:0] ino);
      logic [31:0] idx;
      logic [31:0] blk;
      logic [9:0]  off;
      idx = ino - 32'd1;
      blk = idx / ilfu_pkg::INODES_PER_BLOCK + table_start;
      off = 10'((idx % ilfu_pkg::INODES_PER_BLOCK) * ilfu_pkg::INODE_BYTES);
      return {blk, off};
   endfunction

   function automatic ilfu_pkg::rsp_type apply_request(ilfu_pkg::req_type r);
      ilfu_pkg::rsp_type o;
      int                pick;
      o    = '0;
      pick = -1;
      if (r.op == ilfu_pkg::OP_GET) begin
         {o.disk_block, o.byte_offset} = inode_location(r.inode_number);
         for (int i = 0; i < ilfu_pkg::NUM_SLOTS; i++) begin
            if (cached_valid[i] && cached_device[i] == r.device &&
                cached_inode[i] == r.inode_number) begin
               if (share_cnt[i] != ilfu_pkg::SHARE_MAX) share_cnt[i]++;
               if (use_cnt[i] != ilfu_pkg::USE_MAX) use_cnt[i]++;
               o.slot = ilfu_pkg::SLOT_W'(i);
               o.hit  = 1'b1;
               return o;
            end
         end
         for (int i = 0; i < ilfu_pkg::NUM_SLOTS; i++) begin
            if (!cached_valid[i]) begin
               pick = i;
               break;
            end
         end
         // Only unshared slots may be reclaimed; the lowest index wins a tie.
         if (pick < 0) begin
            for (int i = 0; i < ilfu_pkg::NUM_SLOTS; i++) begin
               if (cached_valid[i] && share_cnt[i] == 8'd0 &&
                   (pick < 0 || use_cnt[i] < use_cnt[pick]))
                  pick = i;
            end
         end
         if (pick < 0) begin
            o.status = ilfu_pkg::STATUS_NO_SLOT;
            return o;
         end
         cached_valid[pick]  = 1'b1;
         cached_device[pick] = r.device;
         cached_inode[pick]  = r.inode_number;
         share_cnt[pick]     = 8'd1;
         use_cnt[pick]       = 16'd1;
         modified[pick]      = 1'b0;
         o.slot        = ilfu_pkg::SLOT_W'(pick);
         o.load_needed = 1'b1;
      end else begin
         o.slot = r.release_slot;
         if (int'(r.release_slot) >= ilfu_pkg::NUM_SLOTS ||
             share_cnt[r.release_slot] == 8'd0) begin
            o.status = ilfu_pkg::STATUS_UNHELD;
            return o;
         end
         if (r.dirty) modified[r.release_slot] = 1'b1;
         share_cnt[r.release_slot]--;
         if (share_cnt[r.release_slot] == 8'd0 && modified[r.release_slot]) begin
            modified[r.release_slot] = 1'b0;
            o.write_back = 1'b1;
            {o.disk_block, o.byte_offset} = inode_location(cached_inode[r.release_slot]);
         end
      end
      return o;
   endfunction

   function automatic ilfu_pkg::rsp_type mk_rsp(logic [5:0] s, logic h, logic ld, logic wb,
                                                logic [31:0] blk, logic [9:0] off,
                                                ilfu_pkg::status_type st);
      ilfu_pkg::rsp_type o;
      o = '{slot: s, hit: h, load_needed: ld, write_back: wb,
            disk_block: blk, byte_offset: off, status: st};
      return o;
   endfunction

   function automatic stim_row_type get_row(logic [7:0] dev, logic [31:0] ino, bit typed,
                                            ilfu_pkg::rsp_type want);
      stim_row_type row;
      row.kind      = ROW_REQ;
      row.request   = '{op: ilfu_pkg::OP_GET, device: dev, inode_number: ino,
                        release_slot: 6'd0, dirty: 1'b0};
      row.typed     = typed;
      row.want      = want;
      row.cfg_value = '0;
      return row;
   endfunction

   function automatic stim_row_type put_row(logic [5:0] s, logic dirty, bit typed,
                                            ilfu_pkg::rsp_type want);
      stim_row_type row;
      row.kind      = ROW_REQ;
      row.request   = '{op: ilfu_pkg::OP_PUT, device: 8'd0, inode_number: 32'd0,
                        release_slot: s, dirty: dirty};
      row.typed     = typed;
      row.want      = want;
      row.cfg_value = '0;
      return row;
   endfunction

   function automatic stim_row_type cfg_row(logic [31:0] value);
      stim_row_type row;
      row           = '{kind: ROW_CFG, request: '0, typed: 1'b0, want: '0, cfg_value: value};
      return row;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 50) return 0;
      if (roll < 90) return int'($urandom_range(1, 3));
      return int'($urandom_range(10, 90));
   endfunction

   // Mostly well-formed traffic: gets of known keys (random keys in fill mode) and puts of held slots.
   function automatic ilfu_pkg::req_type gen_request(traffic_mode_type mode);
      ilfu_pkg::req_type r;
      int                pct;
      int                k;
      int                held[$];
      r.op           = ilfu_pkg::OP_GET;
      r.device       = 8'($urandom);
      r.inode_number = $urandom;
      r.release_slot = 6'($urandom);
      r.dirty        = 1'($urandom);
      case (mode)
         MODE_MIXED: pct = 55;
         MODE_FILL:  pct = 90;
         MODE_DRAIN: pct = 20;
         default:    pct = 100;
      endcase
      if (int'($urandom_range(0, 99)) < pct) begin
         k = (mode == MODE_HAMMER) ? HAMMER_KEY : int'($urandom_range(0, POOL_SIZE - 1));
         if (mode != MODE_FILL && $urandom_range(0, 9) != 0) begin
            r.device       = pool_device[k];
            r.inode_number = pool_inode[k];
         end
      end else begin
         r.op = ilfu_pkg::OP_PUT;
         for (int i = 0; i < ilfu_pkg::NUM_SLOTS; i++)
            if (share_cnt[i] != 8'd0) held.push_back(i);
         if (held.size() != 0 && $urandom_range(0, 9) != 0)
            r.release_slot = ilfu_pkg::SLOT_W'(held[$urandom_range(0, held.size() - 1)]);
      end
      return r;
   endfunction

   // Holds the request until the table takes it, then books its result.
   task automatic send_request(ilfu_pkg::req_type r, bit typed, ilfu_pkg::rsp_type want);
      ilfu_pkg::rsp_type predicted;
      req   <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = apply_request(r);
      pending_rsp.push_back(typed ? want : predicted);
   endtask

   task automatic idle_for(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0 || busy);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_table_start(logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      table_start = value;
   endtask

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s expected %h, actual %h", $time, field, want, got);
      errors++;
   endtask

   always @(posedge clock) begin : check_results
      ilfu_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual %p", $time, rsp);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp.slot !== want.slot)
               report_mismatch("slot", 32'(want.slot), 32'(rsp.slot));
            if (rsp.hit !== want.hit)
               report_mismatch("hit", 32'(want.hit), 32'(rsp.hit));
            if (rsp.load_needed !== want.load_needed)
               report_mismatch("load_needed", 32'(want.load_needed), 32'(rsp.load_needed));
            if (rsp.write_back !== want.write_back)
               report_mismatch("write_back", 32'(want.write_back), 32'(rsp.write_back));
            if (rsp.disk_block !== want.disk_block)
               report_mismatch("disk_block", want.disk_block, rsp.disk_block);
            if (rsp.byte_offset !== want.byte_offset)
               report_mismatch("byte_offset", 32'(want.byte_offset), 32'(rsp.byte_offset));
            if (rsp.status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp.status));
         end
      end
   end

   initial begin
      traffic_mode_type mode;
      logic [31:0]      cfg_value;
      int               sent;
      int               phase;
      int               count;
      bit               quiet;

      for (int i = 0; i < ilfu_pkg::NUM_SLOTS; i++) begin
         cached_valid[i]  = 1'b0;
         cached_device[i] = '0;
         cached_inode[i]  = '0;
         share_cnt[i]     = '0;
         use_cnt[i]       = '0;
         modified[i]      = 1'b0;
      end
      table_start = '0;
      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_device[k] = 8'($urandom);
         pool_inode[k]  = $urandom;
      end
      pool_inode[0]  = 32'd0;
      pool_device[1] = 8'hFF;
      pool_inode[1]  = 32'hFFFF_FFFF;
      pool_device[HAMMER_KEY] = 8'h00;
      pool_inode[HAMMER_KEY]  = 32'd1;

      // Table start is 0 from reset until the first register write.
      directed_rows.push_back(get_row(8'h00, 32'd1, 1'b1,
         mk_rsp(6'd0, 1'b0, 1'b1, 1'b0, 32'd0, 10'd0, ilfu_pkg::STATUS_OK)));
      directed_rows.push_back(get_row(8'hFF, 32'hFFFF_FFFF, 1'b1,
         mk_rsp(6'd1, 1'b0, 1'b1, 1'b0, 32'h3FFF_FFFF, 10'd512, ilfu_pkg::STATUS_OK)));
      directed_rows.push_back(get_row(8'h00, 32'd1, 1'b1,
         mk_rsp(6'd0, 1'b1, 1'b0, 1'b0, 32'd0, 10'd0, ilfu_pkg::STATUS_OK)));
      // Inode number zero wraps to the last entry of the last block.
      directed_rows.push_back(get_row(8'h5A, 32'd0, 1'b1,
         mk_rsp(6'd2, 1'b0, 1'b1, 1'b0, 32'h3FFF_FFFF, 10'd768, ilfu_pkg::STATUS_OK)));
      directed_rows.push_back(put_row(6'd0, 1'b1, 1'b1,
         mk_rsp(6'd0, 1'b0, 1'b0, 1'b0, 32'd0, 10'd0, ilfu_pkg::STATUS_OK)));
      directed_rows.push_back(put_row(6'd0, 1'b0, 1'b1,
         mk_rsp(6'd0, 1'b0, 1'b0, 1'b1, 32'd0, 10'd0, ilfu_pkg::STATUS_OK)));
      directed_rows.push_back(put_row(6'd0, 1'b0, 1'b1,
         mk_rsp(6'd0, 1'b0, 1'b0, 1'b0, 32'd0, 10'd0, ilfu_pkg::STATUS_UNHELD)));
      directed_rows.push_back(put_row(6'd63, 1'b1, 1'b1,
         mk_rsp(6'd63, 1'b0, 1'b0, 1'b0, 32'd0, 10'd0, ilfu_pkg::STATUS_UNHELD)));
      // A cached slot that nobody shares still hits.
      directed_rows.push_back(get_row(8'h00, 32'd1, 1'b1,
         mk_rsp(6'd0, 1'b1, 1'b0, 1'b0, 32'd0, 10'd0, ilfu_pkg::STATUS_OK)));
      directed_rows.push_back(put_row(6'd2, 1'b1, 1'b1,
         mk_rsp(6'd2, 1'b0, 1'b0, 1'b1, 32'h3FFF_FFFF, 10'd768, ilfu_pkg::STATUS_OK)));
      directed_rows.push_back(get_row(8'h00, 32'd2, 1'b1,
         mk_rsp(6'd3, 1'b0, 1'b1, 1'b0, 32'd0, 10'd256, ilfu_pkg::STATUS_OK)));
      directed_rows.push_back(get_row(8'h01, 32'd1, 1'b0, '0));
      directed_rows.push_back(cfg_row(32'hFFFF_FFFF));
      // The block number wraps past the top of the disk.
      directed_rows.push_back(get_row(8'h01, 32'd9, 1'b1,
         mk_rsp(6'd5, 1'b0, 1'b1, 1'b0, 32'd1, 10'd0, ilfu_pkg::STATUS_OK)));
      directed_rows.push_back(get_row(8'h80, 32'd7, 1'b0, '0));
      directed_rows.push_back(put_row(6'd5, 1'b1, 1'b0, '0));
      directed_rows.push_back(put_row(6'd4, 1'b0, 1'b0, '0));
      directed_rows.push_back(cfg_row(32'h1234_5678));
      directed_rows.push_back(get_row(8'hFF, 32'hFFFF_FFFF, 1'b0, '0));
      directed_rows.push_back(get_row(8'hA5, 32'h8000_0001, 1'b0, '0));
      directed_rows.push_back(put_row(6'd1, 1'b1, 1'b0, '0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            wait_idle();
            write_table_start(directed_rows[i].cfg_value);
         end else begin
            send_request(directed_rows[i].request, directed_rows[i].typed,
                         directed_rows[i].want);
            idle_for(pick_gap());
         end
      end

      // Each phase starts from an idle table with a new table start.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            0:       cfg_value = 32'hFFFF_FFFF;
            1:       cfg_value = 32'd0;
            2:       cfg_value = 32'h8000_0000;
            default: cfg_value = $urandom;
         endcase
         wait_idle();
         write_table_start(cfg_value);
         if (phase == 3) begin
            mode  = MODE_HAMMER;
            count = 270;
         end else begin
            case (phase % 3)
               0:       mode = MODE_MIXED;
               1:       mode = MODE_FILL;
               default: mode = MODE_DRAIN;
            endcase
            count = 150;
         end
         if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
         quiet = (phase % 4 == 1);
         repeat (count) begin
            send_request(gen_request(mode), 1'b0, '0);
            sent++;
            if (!quiet) idle_for(pick_gap());
         end
         phase++;
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> inode_cache_lfu_table_top.f
+incdir+design
design/ilfu_pkg.sv
design/ilfu_locate.sv
design/inode_cache_lfu_table_top.sv
design/ilfu_checker.sv
tb/inode_cache_lfu_table_top_tb.sv
